// ----- hdl/fbc_pkg.sv -----
// Package for the frustum box cull core: item record and classification codes.
// Used by fbc_cell and frustum_box_cull_core; no dependencies.
package fbc_pkg;

	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int IDX_W           = 3;
	localparam int IN_DATA_W       = 328;
	localparam int OUT_DATA_W      = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam logic [1:0] CLS_OUTSIDE   = 2'd0;
	localparam logic [1:0] CLS_INSIDE    = 2'd1;
	localparam logic [1:0] CLS_INTERSECT = 2'd2;

	// One request as it travels down the chain of plane cells
	typedef struct packed {
		logic                vld;
		logic                op;
		logic [IDX_W-1:0]    idx;
		logic [FIELD_W-1:0]  pa;
		logic [FIELD_W-1:0]  pb;
		logic [FIELD_W-1:0]  pc;
		logic [FIELD_W-1:0]  pd;
		logic [FIELD_W-1:0]  min_x;
		logic [FIELD_W-1:0]  min_y;
		logic [FIELD_W-1:0]  min_z;
		logic [FIELD_W-1:0]  max_x;
		logic [FIELD_W-1:0]  max_y;
		logic [FIELD_W-1:0]  max_z;
		logic                outside;
		logic                isect;
	} item_t;

endpackage

// ----- hdl/fbc_cell.sv -----
// One plane cell: holds one plane and tests the passing box against it in three stages.
// Depends on fbc_pkg.
module fbc_cell #(
	parameter int VW      = 32,
	parameter int CELL_ID = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fbc_pkg::item_t din,
	output fbc_pkg::item_t dout
);
	import fbc_pkg::*;

	localparam int PW = 2 * VW;
	localparam int SW = 2 * VW + 2;

	logic [FIELD_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [VW-1:0] a_v, b_v, c_v, mnx, mny, mnz, mxx, mxy, mxz;

	item_t it_s1, it_s2, it_s3;
	item_t nxt_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0] ax_s1 [2];
	logic signed [PW-1:0] by_s1 [2];
	logic signed [PW-1:0] cz_s1 [2];
	logic signed [VW-1:0] d_s1;
	logic signed [SW-1:0] xy_s2 [4];
	logic signed [SW-1:0] zd_s2 [2];
	logic signed [SW-1:0] dsh;
	logic [7:0] cin;

	// Reduce stored and box values to the working width
	assign a_v = signed'(a_q[VW-1:0]);
	assign b_v = signed'(b_q[VW-1:0]);
	assign c_v = signed'(c_q[VW-1:0]);
	assign mnx = signed'(din.min_x[VW-1:0]);
	assign mny = signed'(din.min_y[VW-1:0]);
	assign mnz = signed'(din.min_z[VW-1:0]);
	assign mxx = signed'(din.max_x[VW-1:0]);
	assign mxy = signed'(din.max_y[VW-1:0]);
	assign mxz = signed'(din.max_z[VW-1:0]);

	// Plane load: a load request addressed to this cell replaces its plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
		end else if (en && din.vld && din.op == OP_LOAD && 32'(din.idx) == CELL_ID) begin
			a_q <= din.pa;
			b_q <= din.pb;
			c_q <= din.pc;
			d_q <= din.pd;
		end
	end

	// Valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: six products against the current plane, d captured with them
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1    <= din;
			ax_s1[0] <= PW'(a_v) * PW'(mnx);
			ax_s1[1] <= PW'(a_v) * PW'(mxx);
			by_s1[0] <= PW'(b_v) * PW'(mny);
			by_s1[1] <= PW'(b_v) * PW'(mxy);
			cz_s1[0] <= PW'(c_v) * PW'(mnz);
			cz_s1[1] <= PW'(c_v) * PW'(mxz);
			d_s1     <= signed'(d_q[VW-1:0]);
		end
	end

	assign dsh = SW'(d_s1) <<< 16;

	// Stage 2: x+y partial sums for four corner pairs, z+d for two
	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			for (int k = 0; k < 4; k++)
				xy_s2[k] <= SW'(ax_s1[k & 1]) + SW'(by_s1[(k >> 1) & 1]);
			for (int k = 0; k < 2; k++)
				zd_s2[k] <= SW'(cz_s1[k]) + dsh;
		end
	end

	// Corner signs: negative means the corner is in
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			logic signed [SW-1:0] s;
			s = xy_s2[k & 3] + zd_s2[k >> 2];
			cin[k] = s[SW-1];
		end
	end

	// Fold this plane into the running classification
	always_comb begin
		nxt_s3 = it_s2;
		if (it_s2.op == OP_TEST && !it_s2.outside) begin
			if (cin == 8'h00)
				nxt_s3.outside = 1'b1;
			else if (cin != 8'hFF)
				nxt_s3.isect = 1'b1;
		end
	end

	// Stage 3: register the updated request
	always_ff @(posedge clk) begin
		if (en) begin
			it_s3 <= nxt_s3;
		end
	end

	always_comb begin
		dout     = it_s3;
		dout.vld = vld_s3;
	end

endmodule

// ----- hdl/frustum_box_cull_core.sv -----
// Top level of the frustum box cull core: chain of plane cells and output register.
// Depends on fbc_pkg and fbc_cell.

// Classifies axis-aligned boxes against PLANE_COUNT frustum planes. Plane loads
// and box tests share one input stream (tuser = operation) and travel in order
// down a chain of one cell per plane, so a load only affects boxes sent after it.
// One request is taken per cycle unless stalled; a box result passes the three
// stages (products, partial sums, corner signs) of each plane cell, then the
// output register. Loads give no result. Output back-pressure stalls the whole
// chain. Planes reset to zero, so every box is outside until loaded.
module frustum_box_cull_core #(
	parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF,
	parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// plane_index, plane_a, plane_b, plane_c, plane_d, min_x, min_y, min_z,
	// max_x, max_y, max_z, zero fill
	input  logic [fbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// classification, zero fill
	output logic [fbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import fbc_pkg::*;

	localparam int VW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

	item_t chain [PLANE_COUNT+1];
	logic en;
	logic out_vld_q;
	logic [1:0] cls_q;

	// Chain advances whenever the output register is free or being taken
	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Unpack the input request
	always_comb begin
		chain[0].vld     = s_axis_tvalid;
		chain[0].op      = s_axis_tuser;
		chain[0].idx     = s_axis_tdata[2:0];
		chain[0].pa      = s_axis_tdata[34:3];
		chain[0].pb      = s_axis_tdata[66:35];
		chain[0].pc      = s_axis_tdata[98:67];
		chain[0].pd      = s_axis_tdata[130:99];
		chain[0].min_x   = s_axis_tdata[162:131];
		chain[0].min_y   = s_axis_tdata[194:163];
		chain[0].min_z   = s_axis_tdata[226:195];
		chain[0].max_x   = s_axis_tdata[258:227];
		chain[0].max_y   = s_axis_tdata[290:259];
		chain[0].max_z   = s_axis_tdata[322:291];
		chain[0].outside = 1'b0;
		chain[0].isect   = 1'b0;
	end

	// One cell per plane
	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
		fbc_cell #(
			.VW      (VW),
			.CELL_ID (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// Output register: only box tests give a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[PLANE_COUNT].vld && chain[PLANE_COUNT].op == OP_TEST;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (chain[PLANE_COUNT].outside)
				cls_q <= CLS_OUTSIDE;
			else if (chain[PLANE_COUNT].isect)
				cls_q <= CLS_INTERSECT;
			else
				cls_q <= CLS_INSIDE;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, cls_q};

endmodule
